[rtl/core/dttf_pkg.sv]
// ============================================================================
// dttf_pkg
// Shared types and constants for the decimal text to fixed point converter.
// ============================================================================
package dttf_pkg;

    localparam int MANT_W     = 60;
    localparam int FRAC_CNT_W = 5;
    localparam int VALUE_W    = 48;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic [VALUE_W-1:0] POS_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] NEG_LIMIT = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } res_item_t;

    typedef enum logic [2:0] {
        PH_SIGN   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        ST_PARSE = 3'b001,
        ST_DIV   = 3'b010,
        ST_EMIT  = 3'b100
    } seq_state_t;

    // Powers of ten; indexes above 18 clamp to ten to the eighteenth.
    function automatic logic [63:0] pow10(input logic [FRAC_CNT_W-1:0] idx);
        logic [63:0] p;
        unique case (idx)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            default: p = 64'd1000000000000000000;
        endcase
        return p;
    endfunction

endpackage

[rtl/core/decimal_text_to_fixed_top.sv]
// ============================================================================
// decimal_text_to_fixed_top
// Converts a decimal number given as text into signed fixed point.
// ----------------------------------------------------------------------------
// Characters arrive one per transaction on the char channel (valid/ready);
// last_char marks the final character of a string. Each character is
// parsed in the cycle it is accepted, so a string streams in at one
// character per cycle. The transaction that carries last_char starts the
// scaling divide, a restoring divider that produces one quotient bit per
// cycle for each of the 60 + FRAC_BITS dividend bits. During the divide
// char_ready is low. It stays low until the result moves into the output
// register, and the next string may start while that result waits.
// The result leaves on the res channel (valid/ready). If the receiver
// stalls, the result holds in the output register, characters of the next
// string are still taken, and the following divide waits to load its
// result until the register is free. Reset clears the parser to the sign
// phase and empties the output register.
// ============================================================================
module decimal_text_to_fixed_top #(
    parameter int MAX_DIGITS = 18,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_ready,
    input  dttf_pkg::char_item_t  char_item,
    output logic                  res_valid,
    input  logic                  res_ready,
    output dttf_pkg::res_item_t   res_item
);
    import dttf_pkg::*;

    localparam int DIV_W = MANT_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);
    localparam logic [63:0] CAP = pow10(FRAC_CNT_W'(MAX_DIGITS)) - 64'd1;
    localparam logic [FRAC_CNT_W-1:0] MAX_FRAC = FRAC_CNT_W'(MAX_DIGITS);

    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       neg_reg, neg_next;
    logic       dot_reg, dot_next;
    logic       ovf_reg, ovf_next;
    logic [MANT_W-1:0]     mant_reg, mant_next;
    logic [FRAC_CNT_W-1:0] frac_reg, frac_next;

    logic [DIV_W-1:0]   dvd_reg, dvd_next;
    logic [MANT_W-1:0]  rem_reg, rem_next;
    logic [MANT_W-1:0]  p_reg, p_next;
    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic               big_reg, big_next;
    logic               dneg_reg, dneg_next;
    logic               sat_reg, sat_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic      res_valid_reg, res_valid_next;
    res_item_t res_item_reg, res_item_next;

    logic        accept;
    logic [7:0]  ch;
    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] cand;
    logic        go_digits;
    logic [63:0] p_load;

    logic [MANT_W:0]    rem_sh;
    logic               ge;
    logic [VALUE_W-1:0] limit;
    logic               fin_sat;
    logic [VALUE_W-1:0] mag;
    logic               load_out;

    assign char_ready = (state_reg == ST_PARSE);
    assign accept     = char_valid && char_ready;
    assign res_valid  = res_valid_reg;
    assign res_item   = res_item_reg;

    assign ch       = char_item.char_code;
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign digit    = 4'(ch - CHAR_ZERO);
    assign cand     = ({4'd0, mant_reg} << 3) + ({4'd0, mant_reg} << 1) + 64'(digit);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        dot_next   = dot_reg;
        mant_next  = mant_reg;
        frac_next  = frac_reg;
        ovf_next   = ovf_reg;
        go_digits  = 1'b0;
        unique case (phase_reg)
            PH_SIGN:
            begin
                if (ch == CHAR_MINUS)
                begin
                    neg_next = !neg_reg;
                end
                else if (ch != CHAR_PLUS)
                begin
                    go_digits = 1'b1;
                end
            end
            PH_DIGITS: go_digits = 1'b1;
            PH_DONE:   go_digits = 1'b0;
            default:   go_digits = 1'b0;
        endcase
        if (go_digits)
        begin
            phase_next = PH_DIGITS;
            if (is_digit)
            begin
                if (!ovf_reg)
                begin
                    if (dot_reg && (frac_reg >= MAX_FRAC))
                    begin
                        ovf_next = 1'b1;
                    end
                    else if (cand > CAP)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        mant_next = cand[MANT_W-1:0];
                        if (dot_reg)
                        begin
                            frac_next = frac_reg + FRAC_CNT_W'(1);
                        end
                    end
                end
            end
            else if (ch == CHAR_DOT)
            begin
                if (dot_reg)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    dot_next = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    assign p_load = pow10(frac_next);

    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, p_reg};

    assign limit   = dneg_reg ? NEG_LIMIT : POS_LIMIT;
    assign fin_sat = sat_reg || big_reg || (quo_reg > limit);
    assign mag     = fin_sat ? limit : quo_reg;
    assign load_out = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);

    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        p_next         = p_reg;
        quo_next       = quo_reg;
        big_next       = big_reg;
        dneg_next      = dneg_reg;
        sat_next       = sat_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_PARSE:
            begin
                if (accept && char_item.last_char)
                begin
                    dvd_next   = DIV_W'(mant_next) << FRAC_BITS;
                    rem_next   = '0;
                    p_next     = p_load[MANT_W-1:0];
                    quo_next   = '0;
                    big_next   = 1'b0;
                    dneg_next  = neg_next;
                    sat_next   = ovf_next;
                    cnt_next   = CNT_W'(DIV_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dvd_next = dvd_reg << 1;
                rem_next = ge ? MANT_W'(rem_sh - {1'b0, p_reg}) : rem_sh[MANT_W-1:0];
                quo_next = {quo_reg[VALUE_W-2:0], ge};
                big_next = big_reg || quo_reg[VALUE_W-1];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    res_valid_next         = 1'b1;
                    res_item_next.value    = dneg_reg ? -mag : mag;
                    res_item_next.overflow = fin_sat;
                    state_next             = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PARSE;
            phase_reg     <= PH_SIGN;
            neg_reg       <= 1'b0;
            dot_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            mant_reg      <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                if (char_item.last_char)
                begin
                    phase_reg <= PH_SIGN;
                    neg_reg   <= 1'b0;
                    dot_reg   <= 1'b0;
                    ovf_reg   <= 1'b0;
                    mant_reg  <= '0;
                    frac_reg  <= '0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    dot_reg   <= dot_next;
                    ovf_reg   <= ovf_next;
                    mant_reg  <= mant_next;
                    frac_reg  <= frac_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        p_reg        <= p_next;
        quo_reg      <= quo_next;
        big_reg      <= big_next;
        dneg_reg     <= dneg_next;
        sat_reg      <= sat_next;
        res_item_reg <= res_item_next;
    end

    // The running remainder always stays below the divisor.
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < p_reg))
        else $error("Divider remainder is not below the divisor.");

    // The step counter never runs past the dividend width.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DIV_W))
        else $error("Divider step counter is out of range.");

    // A saturated result carries one of the two limit values.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.overflow) |->
            (res_item.value == POS_LIMIT) || (res_item.value == NEG_LIMIT))
        else $error("Overflow result does not hold a limit value.");

    // The divide finishes exactly when the last step is taken.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (cnt_reg == CNT_W'(1))) |=> (state_reg == ST_EMIT))
        else $error("Divider did not finish after its last step.");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for the decimal text to fixed point converter.
// Number strings are streamed in one character per transaction. Each
// accepted character updates a local parser model, and a string's final
// character queues the expected fixed point value and overflow flag. Every
// result transaction is checked against the oldest queued expectation.
// Directed strings come first, then random strings under three idling mixes.
// ============================================================================
module testbench;

    import dttf_pkg::*;

    localparam int MAX_DIGITS      = 18;
    localparam int FRAC_BITS       = 16;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 100;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       char_valid;
    logic       char_ready;
    char_item_t char_item;
    logic       res_valid;
    logic       res_ready;
    res_item_t  res_item;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count = 0;
    int stalled_cycles = 0;

    logic [7:0] text_buf[$];
    res_item_t  expected_values[$];

    phase_t      txt_phase;
    logic        txt_negative;
    logic        txt_seen_dot;
    logic        txt_overflowed;
    logic [63:0] txt_mantissa;
    logic [4:0]  txt_frac_digits;

    decimal_text_to_fixed_top #(
        .MAX_DIGITS (MAX_DIGITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [63:0] ten_to(input int n);
        logic [63:0] p = 64'd1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    task automatic clear_parser();
        txt_phase       = PH_SIGN;
        txt_negative    = 1'b0;
        txt_seen_dot    = 1'b0;
        txt_overflowed  = 1'b0;
        txt_mantissa    = '0;
        txt_frac_digits = '0;
    endtask

    task automatic parse_char(input char_item_t c);
        logic [7:0]  ch;
        logic [63:0] d;
        logic [63:0] cap;
        logic [63:0] limit;
        logic [63:0] p;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] neg;
        logic        sat;
        res_item_t   result;
        ch  = c.char_code;
        cap = ten_to(MAX_DIGITS) - 64'd1;
        if (txt_phase != PH_DONE)
        begin
            if (txt_phase == PH_SIGN && ch == CHAR_MINUS)
            begin
                txt_negative = !txt_negative;
            end
            else if (!(txt_phase == PH_SIGN && ch == CHAR_PLUS))
            begin
                txt_phase = PH_DIGITS;
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                begin
                    d = 64'(ch - CHAR_ZERO);
                    if (txt_overflowed)
                    begin
                    end
                    else if (txt_seen_dot && txt_frac_digits >= MAX_DIGITS)
                    begin
                        txt_overflowed = 1'b1;
                    end
                    else if (txt_mantissa > (cap - d) / 64'd10)
                    begin
                        txt_overflowed = 1'b1;
                    end
                    else
                    begin
                        txt_mantissa = txt_mantissa * 64'd10 + d;
                        if (txt_seen_dot)
                        begin
                            txt_frac_digits = txt_frac_digits + 5'd1;
                        end
                    end
                end
                else if (ch == CHAR_DOT)
                begin
                    if (txt_seen_dot)
                    begin
                        txt_phase = PH_DONE;
                    end
                    else
                    begin
                        txt_seen_dot = 1'b1;
                    end
                end
                else
                begin
                    txt_phase = PH_DONE;
                end
            end
        end
        if (c.last_char)
        begin
            limit = txt_negative ? 64'(NEG_LIMIT) : 64'(POS_LIMIT);
            p     = ten_to((txt_frac_digits > MAX_DIGITS) ? MAX_DIGITS : int'(txt_frac_digits));
            q     = txt_mantissa / p;
            r     = txt_mantissa % p;
            frac  = '0;
            mag   = '0;
            sat   = txt_overflowed;
            if (!sat && q > (limit >> FRAC_BITS))
            begin
                sat = 1'b1;
            end
            if (!sat)
            begin
                for (int b = 0; b < FRAC_BITS; b++)
                begin
                    r    = r << 1;
                    frac = frac << 1;
                    if (r >= p)
                    begin
                        r       = r - p;
                        frac[0] = 1'b1;
                    end
                end
                mag = (q << FRAC_BITS) | frac;
                if (mag > limit)
                begin
                    sat = 1'b1;
                end
            end
            if (sat)
            begin
                mag = limit;
            end
            neg             = 64'd0 - mag;
            result.value    = txt_negative ? neg[VALUE_W-1:0] : mag[VALUE_W-1:0];
            result.overflow = sat;
            expected_values.push_back(result);
            clear_parser();
        end
    endtask

    task automatic send_char(input char_item_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_item  <= c;
        do
        begin
            @(posedge clk);
        end
        while (!char_ready);
        parse_char(c);
    endtask

    task automatic send_text();
        char_item_t c;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            c.char_code = text_buf[i];
            c.last_char = (i == text_buf.size() - 1);
            send_char(c);
        end
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
        send_text();
    endtask

    task automatic test_sign_handling();
        send_string("-");
        send_string("+-5");
        send_string("--7");
        send_string("-0");
    endtask

    task automatic test_fraction_scaling();
        send_string(".5");
        send_string("1.2.3");
        send_string(".");
    endtask

    task automatic test_digit_overflow();
        send_string("9999999999999999999");
        send_string("-9999999999");
    endtask

    task automatic test_terminators();
        text_buf.push_back(8'h00);
        send_text();
        text_buf.push_back(CHAR_ZERO + 8'd7);
        text_buf.push_back(8'hFF);
        text_buf.push_back(CHAR_NINE);
        send_text();
    endtask

    task automatic test_random_strings(input int char_budget);
        int sent;
        int kind;
        int int_len;
        int frac_len;
        sent = 0;
        while (sent < char_budget)
        begin
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    text_buf.push_back(8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(0, 3))
                begin
                    text_buf.push_back($urandom_range(1) ? CHAR_MINUS : CHAR_PLUS);
                end
                int_len = ($urandom_range(9) == 0) ? $urandom_range(15, 20)
                                                   : $urandom_range(0, 7);
                repeat (int_len)
                begin
                    text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                end
                if ($urandom_range(3) != 0)
                begin
                    text_buf.push_back(CHAR_DOT);
                    frac_len = ($urandom_range(9) == 0) ? $urandom_range(15, 20)
                                                        : $urandom_range(0, 7);
                    repeat (frac_len)
                    begin
                        text_buf.push_back(CHAR_ZERO + 8'($urandom_range(9)));
                    end
                end
                if ($urandom_range(4) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        text_buf.push_back(8'($urandom_range(255)));
                    end
                end
                if (kind < 20 && text_buf.size() != 0)
                begin
                    text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
                end
            end
            if (text_buf.size() == 0)
            begin
                text_buf.push_back(8'($urandom_range(255)));
            end
            sent += text_buf.size();
            send_text();
        end
    endtask

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        res_item_t wanted;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_values.size() == 0)
            begin
                $display("%0t: unexpected result, actual value %0d overflow %0b",
                         $time, res_item.value, res_item.overflow);
                mismatch_count++;
            end
            else
            begin
                wanted = expected_values.pop_front();
                if (res_item.value !== wanted.value)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, wanted.value, res_item.value);
                    mismatch_count++;
                end
                if (res_item.overflow !== wanted.overflow)
                begin
                    $display("%0t: overflow mismatch, expected %0b, actual %0b",
                             $time, wanted.overflow, res_item.overflow);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && char_ready) || (res_valid && res_ready))
            begin
                stalled_cycles <= 0;
            end
            else if (stalled_cycles >= WATCHDOG_CYCLES)
            begin
                $display("testbench failed");
                $finish;
            end
            else
            begin
                stalled_cycles <= stalled_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        char_valid    = 1'b0;
        char_item     = '0;
        send_idle_pct = 25;
        recv_idle_pct = 76;
        clear_parser();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_sign_handling();
        test_fraction_scaling();
        test_digit_overflow();
        test_terminators();
        test_random_strings(550);

        send_idle_pct = 76;
        recv_idle_pct = 25;
        test_random_strings(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_strings(550);

        char_valid <= 1'b0;
        while (expected_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_values.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/dttf_pkg.sv
rtl/core/decimal_text_to_fixed_top.sv
sim/testbench.sv
